// ===== src/kmfd_pkg.sv =====
// ----------------------------------------------------------------------------
// kmfd_pkg
// shared constants for the minmod central flux pipeline: default number
// formats, stencil and face counts, and the stage count of each section
// ----------------------------------------------------------------------------
package kmfd_pkg;

   // default working format, signed Q16.16
   localparam int DEF_FRAC_BITS = 16;
   localparam int DEF_WORD_BITS = 32;

   // width of every field on the ports
   localparam int FIELD_W = 32;

   // five-point stencil, two cell faces
   localparam int STENCIL_N  = 5;
   localparam int FACE_N     = 2;
   localparam int FACE_MINUS = 0;
   localparam int FACE_PLUS  = 1;

   // products per face: left flux, right flux, dissipation
   localparam int MUL_PER_FACE = 3;
   localparam int MUL_N        = MUL_PER_FACE * FACE_N;

   // register stages of each pipeline section
   localparam int RECON_STAGES = 5;
   localparam int QMUL_STAGES  = 5;
   localparam int COMB_STAGES  = 4;
   localparam int PIPE_STAGES  = RECON_STAGES + QMUL_STAGES + COMB_STAGES;

endpackage

// ===== src/kmfd_recon.sv =====
// ----------------------------------------------------------------------------
// kmfd_recon
// input saturation, neighbor differences, minmod-limited half slopes and
// left/right face states; also the face speed and the concentration jump
// ----------------------------------------------------------------------------
module kmfd_recon #(
   parameter int WORD_BITS = kmfd_pkg::DEF_WORD_BITS
) (
   input  logic                                   clock,
   input  logic [kmfd_pkg::RECON_STAGES-1:0]      en,
   input  logic signed [kmfd_pkg::FIELD_W-1:0]    vel  [kmfd_pkg::STENCIL_N],
   input  logic signed [kmfd_pkg::FIELD_W-1:0]    conc [kmfd_pkg::STENCIL_N],
   output logic signed [WORD_BITS-1:0]            ul   [kmfd_pkg::FACE_N],
   output logic signed [WORD_BITS-1:0]            ur   [kmfd_pkg::FACE_N],
   output logic signed [WORD_BITS-1:0]            cl   [kmfd_pkg::FACE_N],
   output logic signed [WORD_BITS-1:0]            cr   [kmfd_pkg::FACE_N],
   output logic signed [WORD_BITS-1:0]            spd  [kmfd_pkg::FACE_N],
   output logic signed [WORD_BITS-1:0]            dcd  [kmfd_pkg::FACE_N],
   output logic                                   clip
);

   localparam int W  = WORD_BITS;
   localparam int XW = (W > kmfd_pkg::FIELD_W) ? W : kmfd_pkg::FIELD_W;
   localparam int SN = kmfd_pkg::STENCIL_N;
   localparam int FN = kmfd_pkg::FACE_N;

   localparam logic signed [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  WMIN = ~WMAX;
   localparam logic signed [XW-1:0] XMAX = XW'(WMAX);
   localparam logic signed [XW-1:0] XMIN = ~XMAX;

   typedef struct packed {
      logic                clip;
      logic signed [W-1:0] val;
   } sat_type;

   function automatic sat_type sat_in(input logic signed [XW-1:0] v);
      sat_type r;
      r.clip = (v > XMAX) || (v < XMIN);
      if (!r.clip) begin
         r.val = v[W-1:0];
      end else if (v[XW-1]) begin
         r.val = WMIN;
      end else begin
         r.val = WMAX;
      end
      return r;
   endfunction

   function automatic sat_type sat_sum(input logic signed [W:0] v);
      sat_type r;
      r.clip = (v[W] != v[W-1]);
      if (!r.clip) begin
         r.val = v[W-1:0];
      end else if (v[W]) begin
         r.val = WMIN;
      end else begin
         r.val = WMAX;
      end
      return r;
   endfunction

   // smaller magnitude when both slopes agree in sign, else zero
   function automatic logic signed [W-1:0] minmod(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
      logic a_pos, b_pos;
      a_pos = !a[W-1] && (a != '0);
      b_pos = !b[W-1] && (b != '0);
      if (a_pos && b_pos) begin
         return (a < b) ? a : b;
      end
      if (a[W-1] && b[W-1]) begin
         return (a > b) ? a : b;
      end
      return '0;
   endfunction

   // halve, ties away from zero
   function automatic logic signed [W-1:0] half_rnd(input logic signed [W-1:0] x);
      logic [W:0] xe;
      xe = {1'b0, x} + (W+1)'(1);
      if (x[W-1]) begin
         return x >>> 1;
      end
      return xe[W:1];
   endfunction

   // stage 1: inputs clipped into the word
   logic signed [W-1:0] u1_ff [SN], u1_in [SN];
   logic signed [W-1:0] c1_ff [SN], c1_in [SN];
   logic                clip1_ff, clip1_in;

   // stage 2: neighbor differences
   logic signed [W-1:0] du2_ff [SN-1], du2_in [SN-1];
   logic signed [W-1:0] dc2_ff [SN-1], dc2_in [SN-1];
   logic signed [W-1:0] u2_ff [1:3], c2_ff [1:3];
   logic                clip2_ff, clip2_in;

   // stage 3: half limited slopes of the inner cells
   logic signed [W-1:0] hu3_ff [1:3], hu3_in [1:3];
   logic signed [W-1:0] hc3_ff [1:3], hc3_in [1:3];
   logic signed [W-1:0] u3_ff [1:3], c3_ff [1:3];
   logic                clip3_ff;

   // stage 4: face states
   logic signed [W-1:0] ul4_ff [FN], ul4_in [FN];
   logic signed [W-1:0] ur4_ff [FN], ur4_in [FN];
   logic signed [W-1:0] cl4_ff [FN], cl4_in [FN];
   logic signed [W-1:0] cr4_ff [FN], cr4_in [FN];
   logic                clip4_ff, clip4_in;

   // stage 5: speed and concentration jump
   logic signed [W-1:0] ul5_ff [FN], ur5_ff [FN], cl5_ff [FN], cr5_ff [FN];
   logic signed [W-1:0] spd5_ff [FN], spd5_in [FN];
   logic signed [W-1:0] dcd5_ff [FN], dcd5_in [FN];
   logic                clip5_ff, clip5_in;

   always_comb begin
      sat_type su, sc;
      clip1_in = 1'b0;
      for (int i = 0; i < SN; i++) begin
         su = sat_in(XW'(vel[i]));
         sc = sat_in(XW'(conc[i]));
         u1_in[i] = su.val;
         c1_in[i] = sc.val;
         clip1_in = clip1_in | su.clip | sc.clip;
      end
   end

   always_comb begin
      sat_type su, sc;
      clip2_in = clip1_ff;
      for (int k = 0; k < SN-1; k++) begin
         su = sat_sum((W+1)'(u1_ff[k+1]) - (W+1)'(u1_ff[k]));
         sc = sat_sum((W+1)'(c1_ff[k+1]) - (W+1)'(c1_ff[k]));
         du2_in[k] = su.val;
         dc2_in[k] = sc.val;
         clip2_in  = clip2_in | su.clip | sc.clip;
      end
   end

   always_comb begin
      for (int j = 1; j <= 3; j++) begin
         hu3_in[j] = half_rnd(minmod(du2_ff[j-1], du2_ff[j]));
         hc3_in[j] = half_rnd(minmod(dc2_ff[j-1], dc2_ff[j]));
      end
   end

   // face f sits between cells 1+f and 2+f
   always_comb begin
      sat_type a, b, c, d;
      clip4_in = clip3_ff;
      for (int f = 0; f < FN; f++) begin
         a = sat_sum((W+1)'(u3_ff[1+f]) + (W+1)'(hu3_ff[1+f]));
         b = sat_sum((W+1)'(u3_ff[2+f]) - (W+1)'(hu3_ff[2+f]));
         c = sat_sum((W+1)'(c3_ff[1+f]) + (W+1)'(hc3_ff[1+f]));
         d = sat_sum((W+1)'(c3_ff[2+f]) - (W+1)'(hc3_ff[2+f]));
         ul4_in[f] = a.val;
         ur4_in[f] = b.val;
         cl4_in[f] = c.val;
         cr4_in[f] = d.val;
         clip4_in  = clip4_in | a.clip | b.clip | c.clip | d.clip;
      end
   end

   always_comb begin
      logic signed [W-1:0] ml, mr;
      logic                cl_l, cl_r;
      sat_type             dj;
      clip5_in = clip4_ff;
      for (int f = 0; f < FN; f++) begin
         // magnitude of the most negative word clips
         cl_l = (ul4_ff[f] == WMIN);
         cl_r = (ur4_ff[f] == WMIN);
         ml = cl_l ? WMAX : (ul4_ff[f][W-1] ? -ul4_ff[f] : ul4_ff[f]);
         mr = cl_r ? WMAX : (ur4_ff[f][W-1] ? -ur4_ff[f] : ur4_ff[f]);
         spd5_in[f] = (ml > mr) ? ml : mr;
         dj = sat_sum((W+1)'(cr4_ff[f]) - (W+1)'(cl4_ff[f]));
         dcd5_in[f] = dj.val;
         clip5_in = clip5_in | cl_l | cl_r | dj.clip;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         u1_ff    <= u1_in;
         c1_ff    <= c1_in;
         clip1_ff <= clip1_in;
      end
      if (en[1]) begin
         du2_ff   <= du2_in;
         dc2_ff   <= dc2_in;
         for (int j = 1; j <= 3; j++) begin
            u2_ff[j] <= u1_ff[j];
            c2_ff[j] <= c1_ff[j];
         end
         clip2_ff <= clip2_in;
      end
      if (en[2]) begin
         hu3_ff   <= hu3_in;
         hc3_ff   <= hc3_in;
         u3_ff    <= u2_ff;
         c3_ff    <= c2_ff;
         clip3_ff <= clip2_ff;
      end
      if (en[3]) begin
         ul4_ff   <= ul4_in;
         ur4_ff   <= ur4_in;
         cl4_ff   <= cl4_in;
         cr4_ff   <= cr4_in;
         clip4_ff <= clip4_in;
      end
      if (en[4]) begin
         ul5_ff   <= ul4_ff;
         ur5_ff   <= ur4_ff;
         cl5_ff   <= cl4_ff;
         cr5_ff   <= cr4_ff;
         spd5_ff  <= spd5_in;
         dcd5_ff  <= dcd5_in;
         clip5_ff <= clip5_in;
      end
   end

   assign ul   = ul5_ff;
   assign ur   = ur5_ff;
   assign cl   = cl5_ff;
   assign cr   = cr5_ff;
   assign spd  = spd5_ff;
   assign dcd  = dcd5_ff;
   assign clip = clip5_ff;

endmodule

// ===== src/kmfd_qmul.sv =====
// ----------------------------------------------------------------------------
// kmfd_qmul
// pipelined fixed-point multiply: magnitudes split into halves, four
// partial products, rounding to nearest (ties away) and saturation
// ----------------------------------------------------------------------------
module kmfd_qmul #(
   parameter int FRAC_BITS = kmfd_pkg::DEF_FRAC_BITS,
   parameter int WORD_BITS = kmfd_pkg::DEF_WORD_BITS
) (
   input  logic                               clock,
   input  logic [kmfd_pkg::QMUL_STAGES-1:0]   en,
   input  logic signed [WORD_BITS-1:0]        x,
   input  logic signed [WORD_BITS-1:0]        y,
   input  logic                               clip_in,
   output logic signed [WORD_BITS-1:0]        prod,
   output logic                               clip_out
);

   localparam int W      = WORD_BITS;
   localparam int HALF_W = (W + 1) / 2;
   localparam int EXT_W  = 2 * HALF_W;
   localparam int PP_W   = 2 * HALF_W;
   localparam int MID_W  = PP_W + 1;
   localparam int FULL_W = 2 * EXT_W;

   localparam logic signed [W-1:0] WMAX    = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN    = ~WMAX;
   localparam logic [FULL_W-1:0]   ROUND   = FULL_W'(1) << (FRAC_BITS - 1);
   localparam logic [FULL_W-1:0]   LIM_POS = FULL_W'({1'b0, {(W-1){1'b1}}});
   localparam logic [FULL_W-1:0]   LIM_NEG = LIM_POS + FULL_W'(1);

   // stage 1: magnitudes and product sign
   logic [EXT_W-1:0] a1_ff, b1_ff;
   logic [W-1:0]     ma, mb;
   logic             neg1_ff, clip1_ff;

   // stage 2: partial products
   logic [PP_W-1:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   logic             neg2_ff, clip2_ff;

   // stage 3: middle sum and outer pair
   logic [MID_W-1:0]  mid3_ff;
   logic [FULL_W-1:0] hl3_ff;
   logic              neg3_ff, clip3_ff;

   // stage 4: full rounded product
   logic [FULL_W-1:0] full4_ff, full4_in;
   logic              neg4_ff, clip4_ff;

   // stage 5: scaled, signed and saturated
   logic [FULL_W-1:0]   q;
   logic                over;
   logic signed [W-1:0] prod5_ff, prod5_in;
   logic                clip5_ff;

   assign ma = x[W-1] ? W'(-x) : W'(x);
   assign mb = y[W-1] ? W'(-y) : W'(y);

   assign full4_in = hl3_ff + (FULL_W'(mid3_ff) << HALF_W) + ROUND;

   assign q    = full4_ff >> FRAC_BITS;
   assign over = neg4_ff ? (q > LIM_NEG) : (q > LIM_POS);

   always_comb begin
      if (over) begin
         prod5_in = neg4_ff ? WMIN : WMAX;
      end else if (neg4_ff) begin
         prod5_in = -W'(q);
      end else begin
         prod5_in = W'(q);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         a1_ff    <= EXT_W'(ma);
         b1_ff    <= EXT_W'(mb);
         neg1_ff  <= x[W-1] ^ y[W-1];
         clip1_ff <= clip_in;
      end
      if (en[1]) begin
         p00_ff   <= PP_W'(a1_ff[HALF_W-1:0])     * PP_W'(b1_ff[HALF_W-1:0]);
         p01_ff   <= PP_W'(a1_ff[HALF_W-1:0])     * PP_W'(b1_ff[EXT_W-1:HALF_W]);
         p10_ff   <= PP_W'(a1_ff[EXT_W-1:HALF_W]) * PP_W'(b1_ff[HALF_W-1:0]);
         p11_ff   <= PP_W'(a1_ff[EXT_W-1:HALF_W]) * PP_W'(b1_ff[EXT_W-1:HALF_W]);
         neg2_ff  <= neg1_ff;
         clip2_ff <= clip1_ff;
      end
      if (en[2]) begin
         mid3_ff  <= MID_W'(p01_ff) + MID_W'(p10_ff);
         hl3_ff   <= {p11_ff, p00_ff};
         neg3_ff  <= neg2_ff;
         clip3_ff <= clip2_ff;
      end
      if (en[3]) begin
         full4_ff <= full4_in;
         neg4_ff  <= neg3_ff;
         clip4_ff <= clip3_ff;
      end
      if (en[4]) begin
         prod5_ff <= prod5_in;
         clip5_ff <= clip4_ff | over;
      end
   end

   assign prod     = prod5_ff;
   assign clip_out = clip5_ff;

endmodule

// ===== src/kmfd_combine.sv =====
// ----------------------------------------------------------------------------
// kmfd_combine
// face fluxes from the products, difference across the cell and the
// output register with the final clip to the field range
// ----------------------------------------------------------------------------
module kmfd_combine #(
   parameter int WORD_BITS = kmfd_pkg::DEF_WORD_BITS
) (
   input  logic                                clock,
   input  logic [kmfd_pkg::COMB_STAGES-1:0]    en,
   input  logic signed [WORD_BITS-1:0]         fl   [kmfd_pkg::FACE_N],
   input  logic signed [WORD_BITS-1:0]         fr   [kmfd_pkg::FACE_N],
   input  logic signed [WORD_BITS-1:0]         diss [kmfd_pkg::FACE_N],
   input  logic [kmfd_pkg::MUL_N-1:0]          clip_in,
   output logic signed [kmfd_pkg::FIELD_W-1:0] axis_term,
   output logic                                saturated
);

   localparam int W  = WORD_BITS;
   localparam int FW = kmfd_pkg::FIELD_W;
   localparam int XW = (W > FW) ? W : FW;
   localparam int FN = kmfd_pkg::FACE_N;

   localparam logic signed [W-1:0]  WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  WMIN = ~WMAX;
   localparam logic signed [XW-1:0] FMAX = XW'({1'b0, {(FW-1){1'b1}}});
   localparam logic signed [XW-1:0] FMIN = ~FMAX;

   typedef struct packed {
      logic                clip;
      logic signed [W-1:0] val;
   } sat_type;

   function automatic sat_type sat_sum(input logic signed [W:0] v);
      sat_type r;
      r.clip = (v[W] != v[W-1]);
      if (!r.clip) begin
         r.val = v[W-1:0];
      end else if (v[W]) begin
         r.val = WMIN;
      end else begin
         r.val = WMAX;
      end
      return r;
   endfunction

   // halve, ties away from zero
   function automatic logic signed [W-1:0] half_rnd(input logic signed [W-1:0] x);
      logic [W:0] xe;
      xe = {1'b0, x} + (W+1)'(1);
      if (x[W-1]) begin
         return x >>> 1;
      end
      return xe[W:1];
   endfunction

   // stage 1: fL + fR
   logic signed [W-1:0] s1_ff [FN], s1_in [FN];
   logic signed [W-1:0] dis1_ff [FN];
   logic                clip1_ff, clip1_in;

   // stage 2: minus dissipation
   logic signed [W-1:0] t2_ff [FN], t2_in [FN];
   logic                clip2_ff, clip2_in;

   // stage 3: face flux
   logic signed [W-1:0] h3_ff [FN];
   logic                clip3_ff;

   // stage 4: output register
   sat_type              rs;
   logic signed [XW-1:0] rx;
   logic                 fclip;
   logic signed [FW-1:0] term_ff, term_in;
   logic                 sat_ff;

   always_comb begin
      sat_type a;
      clip1_in = |clip_in;
      for (int f = 0; f < FN; f++) begin
         a = sat_sum((W+1)'(fl[f]) + (W+1)'(fr[f]));
         s1_in[f] = a.val;
         clip1_in = clip1_in | a.clip;
      end
   end

   always_comb begin
      sat_type a;
      clip2_in = clip1_ff;
      for (int f = 0; f < FN; f++) begin
         a = sat_sum((W+1)'(s1_ff[f]) - (W+1)'(dis1_ff[f]));
         t2_in[f] = a.val;
         clip2_in = clip2_in | a.clip;
      end
   end

   // H_minus - H_plus, then into the field range
   assign rs = sat_sum((W+1)'(h3_ff[kmfd_pkg::FACE_MINUS])
                       - (W+1)'(h3_ff[kmfd_pkg::FACE_PLUS]));
   assign rx    = XW'(rs.val);
   assign fclip = (rx > FMAX) || (rx < FMIN);

   always_comb begin
      if (!fclip) begin
         term_in = rx[FW-1:0];
      end else if (rx[XW-1]) begin
         term_in = FMIN[FW-1:0];
      end else begin
         term_in = FMAX[FW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_ff    <= s1_in;
         dis1_ff  <= diss;
         clip1_ff <= clip1_in;
      end
      if (en[1]) begin
         t2_ff    <= t2_in;
         clip2_ff <= clip2_in;
      end
      if (en[2]) begin
         for (int f = 0; f < FN; f++) begin
            h3_ff[f] <= half_rnd(t2_ff[f]);
         end
         clip3_ff <= clip2_ff;
      end
      if (en[3]) begin
         term_ff <= term_in;
         sat_ff  <= clip3_ff | rs.clip | fclip;
      end
   end

   assign axis_term = term_ff;
   assign saturated = sat_ff;

endmodule

// ===== src/kt_minmod_flux_divergence.sv =====
// ----------------------------------------------------------------------------
// kt_minmod_flux_divergence
// one axis term of the central flux divergence with minmod slopes
// ----------------------------------------------------------------------------
// usage:
//   req channel: one item per five-point stencil (offsets -2..+2) of the
//   axis velocity and the concentration, signed Q16.16 by default; taken
//   at a clock edge with req_valid high and req_stall low
//   rsp channel: rsp_axis_term = -(H_plus - H_minus) and rsp_saturated,
//   set when any step of the item clipped; taken with rsp_valid high and
//   rsp_stall low; results leave in the order the items came in
//   throughput: one item per cycle, sustained while the receiver takes
//   results; every stage holds its own valid bit
//   pipeline: 14 register stages (5 reconstruction stages, 5 multiplier
//   stages, 4 combining stages, the last one the output register)
//   stall: a stalled result holds in the output register; stages behind
//   it keep moving into empty slots, and req_stall rises only when every
//   stage holds an item
//   reset: clears all valid bits, the pipeline comes up empty
// ----------------------------------------------------------------------------
module kt_minmod_flux_divergence #(
   parameter int FRAC_BITS = kmfd_pkg::DEF_FRAC_BITS,
   parameter int WORD_BITS = kmfd_pkg::DEF_WORD_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // stencil in
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [kmfd_pkg::FIELD_W-1:0] req_vel_m2,
   input  logic signed [kmfd_pkg::FIELD_W-1:0] req_vel_m1,
   input  logic signed [kmfd_pkg::FIELD_W-1:0] req_vel_c0,
   input  logic signed [kmfd_pkg::FIELD_W-1:0] req_vel_p1,
   input  logic signed [kmfd_pkg::FIELD_W-1:0] req_vel_p2,
   input  logic signed [kmfd_pkg::FIELD_W-1:0] req_conc_m2,
   input  logic signed [kmfd_pkg::FIELD_W-1:0] req_conc_m1,
   input  logic signed [kmfd_pkg::FIELD_W-1:0] req_conc_c0,
   input  logic signed [kmfd_pkg::FIELD_W-1:0] req_conc_p1,
   input  logic signed [kmfd_pkg::FIELD_W-1:0] req_conc_p2,
   // axis term out
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [kmfd_pkg::FIELD_W-1:0] rsp_axis_term,
   output logic                                rsp_saturated
);

   localparam int NS  = kmfd_pkg::PIPE_STAGES;
   localparam int RS  = kmfd_pkg::RECON_STAGES;
   localparam int QS  = kmfd_pkg::QMUL_STAGES;
   localparam int CS  = kmfd_pkg::COMB_STAGES;
   localparam int FN  = kmfd_pkg::FACE_N;
   localparam int MPF = kmfd_pkg::MUL_PER_FACE;

   // stencil as arrays, offset -2 first
   logic signed [kmfd_pkg::FIELD_W-1:0] vel  [kmfd_pkg::STENCIL_N];
   logic signed [kmfd_pkg::FIELD_W-1:0] conc [kmfd_pkg::STENCIL_N];

   assign vel[0]  = req_vel_m2;
   assign vel[1]  = req_vel_m1;
   assign vel[2]  = req_vel_c0;
   assign vel[3]  = req_vel_p1;
   assign vel[4]  = req_vel_p2;
   assign conc[0] = req_conc_m2;
   assign conc[1] = req_conc_m1;
   assign conc[2] = req_conc_c0;
   assign conc[3] = req_conc_p1;
   assign conc[4] = req_conc_p2;

   // ---------------------------------------------------------------------
   // pipeline control: a stage loads when the output is not stalled, when
   // it is empty or when some stage ahead of it has room, so bubbles close
   // up behind a stalled output
   logic [NS:1] v_ff, v_in;
   logic [NS:1] ready;

   for (genvar k = 1; k <= NS; k++) begin : g_ready
      assign ready[k] = !rsp_stall || !(&v_ff[NS:k]);
   end

   always_comb begin
      v_in[1] = ready[1] ? req_valid : v_ff[1];
      for (int k = 2; k <= NS; k++) begin
         v_in[k] = ready[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !ready[1];
   assign rsp_valid = v_ff[NS];

   // ---------------------------------------------------------------------
   // reconstruction: clipped inputs, slopes, face states, speed, jump
   // ---------------------------------------------------------------------
   logic signed [WORD_BITS-1:0] ul [FN], ur [FN], cl [FN], cr [FN];
   logic signed [WORD_BITS-1:0] spd [FN], dcd [FN];
   logic                        recon_clip;

   kmfd_recon #(
      .WORD_BITS (WORD_BITS)
   ) u_recon (
      .clock (clock),
      .en    (ready[RS:1]),
      .vel   (vel),
      .conc  (conc),
      .ul    (ul),
      .ur    (ur),
      .cl    (cl),
      .cr    (cr),
      .spd   (spd),
      .dcd   (dcd),
      .clip  (recon_clip)
   );

   // ---------------------------------------------------------------------
   // products per face: fL = cL*uL, fR = cR*uR, diss = speed * (cR - cL);
   // the reconstruction clip flag rides along with the left flux product of
   // face 0
   logic signed [WORD_BITS-1:0] fl [FN], fr [FN], diss [FN];
   logic [kmfd_pkg::MUL_N-1:0]  mul_clip;

   for (genvar f = 0; f < FN; f++) begin : g_face
      kmfd_qmul #(
         .FRAC_BITS (FRAC_BITS),
         .WORD_BITS (WORD_BITS)
      ) u_mul_left (
         .clock    (clock),
         .en       (ready[RS+QS:RS+1]),
         .x        (cl[f]),
         .y        (ul[f]),
         .clip_in  ((f == 0) ? recon_clip : 1'b0),
         .prod     (fl[f]),
         .clip_out (mul_clip[f*MPF])
      );

      kmfd_qmul #(
         .FRAC_BITS (FRAC_BITS),
         .WORD_BITS (WORD_BITS)
      ) u_mul_right (
         .clock    (clock),
         .en       (ready[RS+QS:RS+1]),
         .x        (cr[f]),
         .y        (ur[f]),
         .clip_in  (1'b0),
         .prod     (fr[f]),
         .clip_out (mul_clip[f*MPF+1])
      );

      kmfd_qmul #(
         .FRAC_BITS (FRAC_BITS),
         .WORD_BITS (WORD_BITS)
      ) u_mul_diss (
         .clock    (clock),
         .en       (ready[RS+QS:RS+1]),
         .x        (spd[f]),
         .y        (dcd[f]),
         .clip_in  (1'b0),
         .prod     (diss[f]),
         .clip_out (mul_clip[f*MPF+2])
      );
   end

   // ---------------------------------------------------------------------
   // face fluxes, cell difference, output register
   // ---------------------------------------------------------------------
   kmfd_combine #(
      .WORD_BITS (WORD_BITS)
   ) u_combine (
      .clock     (clock),
      .en        (ready[NS:NS-CS+1]),
      .fl        (fl),
      .fr        (fr),
      .diss      (diss),
      .clip_in   (mul_clip),
      .axis_term (rsp_axis_term),
      .saturated (rsp_saturated)
   );

endmodule

// ===== tb/tb_kt_minmod_flux_divergence.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_kt_minmod_flux_divergence
// drives five-point stencils into the minmod central flux pipeline and checks
// every axis term and saturation flag against a fixed-point predictor, first
// with hand-picked stencils, then with random ones under changing idle and
// stall patterns, including a long receiver hold-off that backs the pipe up
// ----------------------------------------------------------------------------

typedef struct packed {
   logic [4:0][31:0] vel;    // [0] is offset -2, [4] is offset +2
   logic [4:0][31:0] conc;
} stencil_type;

typedef struct packed {
   logic [31:0] value;
   logic        saturated;
} axis_term_type;

class flux_scoreboard;
   axis_term_type expected_terms[$];
   int            failures;
   longint        word_max;
   longint        word_min;
   bit            clipped;

   function new();
      word_max = (longint'(1) <<< (kmfd_pkg::DEF_WORD_BITS - 1)) - 1;
      word_min = -word_max - 1;
      failures = 0;
   endfunction

   function longint clamp(longint v);
      if (v > word_max) begin
         clipped = 1'b1;
         return word_max;
      end
      if (v < word_min) begin
         clipped = 1'b1;
         return word_min;
      end
      return v;
   endfunction

   function longint magnitude(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // round to nearest, ties away from zero
   function longint halve(longint v);
      if (v < 0)
         return -((magnitude(v) + 1) >>> 1);
      return (v + 1) >>> 1;
   endfunction

   function longint minmod(longint a, longint b);
      if (a > 0 && b > 0)
         return (a < b) ? a : b;
      if (a < 0 && b < 0)
         return (a > b) ? a : b;
      return 0;
   endfunction

   // signed fixed-point product, rounded on the magnitude, then saturated
   function longint fx_mul(longint x, longint y);
      logic [127:0] prod;
      logic [127:0] cap;
      bit           neg;
      neg  = (x < 0) != (y < 0);
      prod = 128'(magnitude(x)) * 128'(magnitude(y));
      prod = (prod + (128'd1 << (kmfd_pkg::DEF_FRAC_BITS - 1)))
             >> kmfd_pkg::DEF_FRAC_BITS;
      cap  = neg ? 128'(word_max) + 128'd1 : 128'(word_max);
      if (prod > cap) begin
         clipped = 1'b1;
         return neg ? word_min : word_max;
      end
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
   endfunction

   // local Lax-Friedrichs flux through the face between cells l and r
   function longint face_flux(longint ull, longint ul, longint ur, longint urr,
                              longint cll, longint cl, longint cr, longint crr);
      longint du, dc, su_l, su_r, sc_l, sc_r;
      longint u_left, u_right, c_left, c_right;
      longint f_left, f_right, m_left, m_right, speed, diss, total;
      du      = clamp(ur - ul);
      dc      = clamp(cr - cl);
      su_l    = minmod(clamp(ul - ull), du);
      su_r    = minmod(du, clamp(urr - ur));
      sc_l    = minmod(clamp(cl - cll), dc);
      sc_r    = minmod(dc, clamp(crr - cr));
      u_left  = clamp(ul + halve(su_l));
      u_right = clamp(ur - halve(su_r));
      c_left  = clamp(cl + halve(sc_l));
      c_right = clamp(cr - halve(sc_r));
      f_left  = fx_mul(c_left, u_left);
      f_right = fx_mul(c_right, u_right);
      m_left  = clamp(magnitude(u_left));
      m_right = clamp(magnitude(u_right));
      speed   = (m_left > m_right) ? m_left : m_right;
      diss    = fx_mul(speed, clamp(c_right - c_left));
      total   = clamp(f_left + f_right);
      return halve(clamp(total - diss));
   endfunction

   function axis_term_type predict_axis_term(stencil_type s);
      longint        u[5];
      longint        c[5];
      longint        plus_face, minus_face, r;
      axis_term_type t;
      clipped = 1'b0;
      for (int k = 0; k < 5; k++) begin
         u[k] = clamp(longint'($signed(s.vel[k])));
         c[k] = clamp(longint'($signed(s.conc[k])));
      end
      plus_face  = face_flux(u[1], u[2], u[3], u[4], c[1], c[2], c[3], c[4]);
      minus_face = face_flux(u[0], u[1], u[2], u[3], c[0], c[1], c[2], c[3]);
      r = clamp(minus_face - plus_face);
      if (r > 64'sd2147483647) begin
         r = 64'sd2147483647;
         clipped = 1'b1;
      end
      if (r < -64'sd2147483648) begin
         r = -64'sd2147483648;
         clipped = 1'b1;
      end
      t.value     = r[31:0];
      t.saturated = clipped;
      return t;
   endfunction

   function void report(string msg);
      failures++;
      if (failures <= 10)
         $display("%s", msg);
   endfunction

   function void note_stencil(stencil_type s);
      expected_terms.push_back(predict_axis_term(s));
   endfunction

   function void check_term(logic [31:0] value, logic saturated);
      axis_term_type want;
      if (expected_terms.size() == 0) begin
         report($sformatf("unexpected axis term %h sat %b", value, saturated));
         return;
      end
      want = expected_terms.pop_front();
      if (value !== want.value)
         report($sformatf("axis term mismatch: expected %h actual %h",
                          want.value, value));
      if (saturated !== want.saturated)
         report($sformatf("saturated mismatch: expected %b actual %b (term %h)",
                          want.saturated, saturated, want.value));
   endfunction

   function void finish_check();
      if (expected_terms.size() != 0)
         report($sformatf("%0d axis terms never came out", expected_terms.size()));
   endfunction
endclass

module tb_kt_minmod_flux_divergence;

   localparam int ONE_Q       = 65536;            // 1.0 in Q16.16
   localparam int TOP_Q       = 2147483647;
   localparam int BOTTOM_Q    = -2147483647 - 1;
   localparam int HOLD_CYCLES = 60;               // long enough to fill all 14 stages
   localparam int DRAIN_CYCLES = 30;              // past the pipeline latency

   typedef enum {SHAPE_NOISE, SHAPE_SMOOTH, SHAPE_KINK, SHAPE_FAST, SHAPE_EXTREME}
      stencil_shape_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_vel_m2, req_vel_m1, req_vel_c0, req_vel_p1, req_vel_p2;
   logic [31:0] req_conc_m2, req_conc_m1, req_conc_c0, req_conc_p1, req_conc_p2;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_axis_term;
   logic        rsp_saturated;

   flux_scoreboard board;

   // idle and stall odds in percent, set per phase
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   // hold-off handshake between the stimulus and the stall process
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;

   always #5 clock = ~clock;

   kt_minmod_flux_divergence dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_vel_m2    (req_vel_m2),
      .req_vel_m1    (req_vel_m1),
      .req_vel_c0    (req_vel_c0),
      .req_vel_p1    (req_vel_p1),
      .req_vel_p2    (req_vel_p2),
      .req_conc_m2   (req_conc_m2),
      .req_conc_m1   (req_conc_m1),
      .req_conc_c0   (req_conc_c0),
      .req_conc_p1   (req_conc_p1),
      .req_conc_p2   (req_conc_p2),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_axis_term (rsp_axis_term),
      .rsp_saturated (rsp_saturated)
   );

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   function automatic stencil_type mk(int vm2, int vm1, int vc0, int vp1, int vp2,
                                      int cm2, int cm1, int cc0, int cp1, int cp2);
      stencil_type s;
      s.vel[0]  = vm2; s.vel[1]  = vm1; s.vel[2]  = vc0; s.vel[3]  = vp1; s.vel[4]  = vp2;
      s.conc[0] = cm2; s.conc[1] = cm1; s.conc[2] = cc0; s.conc[3] = cp1; s.conc[4] = cp2;
      return s;
   endfunction

   // a field with a base within +-16.0 that is linear, or peaks or dips in the middle for a kink;
   // slopes are sometimes tiny or flat so minmod sees zeros
   function automatic logic [4:0][31:0] smooth_line(bit kink);
      logic [4:0][31:0] line;
      int base, slope, offset, jitter;
      base = int'($urandom_range(2097152)) - 1048576;
      case ($urandom_range(3))
         0:       slope = 0;
         1:       slope = int'($urandom_range(16)) - 8;
         default: slope = int'($urandom_range(131072)) - 65536;
      endcase
      for (int k = 0; k < 5; k++) begin
         offset = kink ? (2 - ((k > 2) ? k - 2 : 2 - k)) * slope : (k - 2) * slope;
         jitter = $urandom_range(1) ? int'($urandom_range(8192)) - 4096 : 0;
         line[k] = base + offset + jitter;
      end
      return line;
   endfunction

   function automatic logic [31:0] extreme_word();
      case ($urandom_range(7))
         0:       return TOP_Q;
         1:       return BOTTOM_Q;
         2:       return 32'd0;
         3:       return 32'd1;
         4:       return -32'sd1;
         5:       return ONE_Q;
         6:       return -ONE_Q;
         default: return $urandom;
      endcase
   endfunction

   function automatic stencil_type random_stencil();
      stencil_type       s;
      stencil_shape_type shape;
      int                pick;
      pick = $urandom_range(99);
      if (pick < 15)      shape = SHAPE_NOISE;
      else if (pick < 55) shape = SHAPE_SMOOTH;
      else if (pick < 75) shape = SHAPE_KINK;
      else if (pick < 88) shape = SHAPE_FAST;
      else                shape = SHAPE_EXTREME;
      case (shape)
         SHAPE_SMOOTH: begin
            s.vel  = smooth_line(1'b0);
            s.conc = smooth_line(1'b0);
         end
         SHAPE_KINK: begin
            s.vel  = smooth_line(1'($urandom_range(1)));
            s.conc = smooth_line(1'b1);
         end
         SHAPE_FAST: begin
            // wide velocity so fluxes and dissipation hit the product limits
            for (int k = 0; k < 5; k++) s.vel[k] = $urandom;
            s.conc = smooth_line(1'($urandom_range(1)));
         end
         SHAPE_EXTREME: begin
            for (int k = 0; k < 5; k++) begin
               s.vel[k]  = extreme_word();
               s.conc[k] = extreme_word();
            end
         end
         default: begin
            for (int k = 0; k < 5; k++) begin
               s.vel[k]  = $urandom;
               s.conc[k] = $urandom;
            end
         end
      endcase
      return s;
   endfunction

   // offer one item after random idle cycles, hold it until taken
   task automatic send_stencil(stencil_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_vel_m2  <= s.vel[0];
      req_vel_m1  <= s.vel[1];
      req_vel_c0  <= s.vel[2];
      req_vel_p1  <= s.vel[3];
      req_vel_p2  <= s.vel[4];
      req_conc_m2 <= s.conc[0];
      req_conc_m1 <= s.conc[1];
      req_conc_c0 <= s.conc[2];
      req_conc_p1 <= s.conc[3];
      req_conc_p2 <= s.conc[4];
      do @(posedge clock); while (req_stall);
      board.note_stencil(s);
   endtask

   task automatic run_phase(int count, int idle_pct, int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) send_stencil(random_stencil());
   endtask

   task automatic directed_stencils();
      // flat fields: zero, one and both rails
      send_stencil(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_stencil(mk(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q));
      send_stencil(mk(TOP_Q, TOP_Q, TOP_Q, TOP_Q, TOP_Q, TOP_Q, TOP_Q, TOP_Q, TOP_Q, TOP_Q));
      send_stencil(mk(BOTTOM_Q, BOTTOM_Q, BOTTOM_Q, BOTTOM_Q, BOTTOM_Q,
                      BOTTOM_Q, BOTTOM_Q, BOTTOM_Q, BOTTOM_Q, BOTTOM_Q));
      // rails crossed; in the first, the magnitude of the most negative velocity saturates
      send_stencil(mk(BOTTOM_Q, BOTTOM_Q, BOTTOM_Q, BOTTOM_Q, BOTTOM_Q,
                      TOP_Q, TOP_Q, TOP_Q, TOP_Q, TOP_Q));
      send_stencil(mk(TOP_Q, TOP_Q, TOP_Q, TOP_Q, TOP_Q,
                      BOTTOM_Q, BOTTOM_Q, BOTTOM_Q, BOTTOM_Q, BOTTOM_Q));
      // rail-to-rail zigzag, every difference clips
      send_stencil(mk(TOP_Q, BOTTOM_Q, TOP_Q, BOTTOM_Q, TOP_Q,
                      BOTTOM_Q, TOP_Q, BOTTOM_Q, TOP_Q, BOTTOM_Q));
      // same-sign slopes, rising and falling
      send_stencil(mk(ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q, 5 * ONE_Q,
                      -2 * ONE_Q, -ONE_Q, 0, ONE_Q, 2 * ONE_Q));
      send_stencil(mk(5 * ONE_Q, 4 * ONE_Q, 3 * ONE_Q, 2 * ONE_Q, ONE_Q,
                      2 * ONE_Q, ONE_Q, 0, -ONE_Q, -2 * ONE_Q));
      // opposite-sign slopes at a peak, minmod gives zero
      send_stencil(mk(ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 2 * ONE_Q, ONE_Q,
                      0, ONE_Q, 3 * ONE_Q, ONE_Q, 0));
      // one flat side
      send_stencil(mk(ONE_Q, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 3 * ONE_Q,
                      ONE_Q, ONE_Q, ONE_Q, 2 * ONE_Q, 2 * ONE_Q));
      // equal slopes on both sides
      send_stencil(mk(0, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 4 * ONE_Q,
                      10 * ONE_Q, 8 * ONE_Q, 6 * ONE_Q, 4 * ONE_Q, 2 * ONE_Q));
      // odd values with slopes of two in both signs
      send_stencil(mk(1, 3, 5, 7, 9, 1, 3, 5, 7, 9));
      send_stencil(mk(-1, -3, -5, -7, -9, -9, -7, -5, -3, -1));
      // product rounding ties in both signs
      send_stencil(mk(1, 1, 1, 1, 1, 32768, 32768, 32768, 32768, 32768));
      send_stencil(mk(-1, -1, -1, -1, -1, 32768, 32768, 32768, 32768, 32768));
      // products far past the word range
      send_stencil(mk(32'h40000000, 32'h40000000, 32'h40000000, 32'h40000000,
                      32'h40000000, 32'h40000000, 32'h40000000, 32'h40000000,
                      32'h40000000, 32'h40000000));
      // mixed-sign velocity, speed picked from either side
      send_stencil(mk(-3 * ONE_Q, -ONE_Q, ONE_Q, 3 * ONE_Q, -2 * ONE_Q,
                      ONE_Q, 4 * ONE_Q, 2 * ONE_Q, 5 * ONE_Q, 3 * ONE_Q));
      // steep concentration swings under a moderate flow
      send_stencil(mk(ONE_Q, 2 * ONE_Q, -ONE_Q, 3 * ONE_Q, ONE_Q,
                      BOTTOM_Q, 0, TOP_Q, 0, BOTTOM_Q));
      send_stencil(mk(TOP_Q, TOP_Q - 1, TOP_Q - 2, TOP_Q - 3, TOP_Q - 4,
                      BOTTOM_Q, BOTTOM_Q + 1, BOTTOM_Q + 2, BOTTOM_Q + 3, BOTTOM_Q + 4));
   endtask

   // ---------------------------------------------------------------------
   // receiver side
   // ---------------------------------------------------------------------

   // stall at the falling edge; a requested hold-off takes precedence
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // results taken at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_term(rsp_axis_term, rsp_saturated);
   end

   // ---------------------------------------------------------------------
   // run
   // ---------------------------------------------------------------------

   initial begin
      board       = new();
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_vel_m2  = '0;
      req_vel_m1  = '0;
      req_vel_c0  = '0;
      req_vel_p1  = '0;
      req_vel_p2  = '0;
      req_conc_m2 = '0;
      req_conc_m1 = '0;
      req_conc_c0 = '0;
      req_conc_p1 = '0;
      req_conc_p2 = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed items back to back
      directed_stencils();

      // random items: free flow, idle sender, stalling receiver, both
      run_phase(400, 0, 0);
      run_phase(350, 58, 0);
      run_phase(350, 0, 58);
      run_phase(350, 30, 30);

      // receiver holds off while items keep coming, the pipe fills and
      // the input stalls
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests  = hold_requests + 1;
      run_phase(120, 0, 0);

      run_phase(200, 30, 30);

      @(negedge clock);
      req_valid <= 1'b0;
      recv_stall_pct = 0;

      // drain, then watch a little longer for stray results
      while (board.expected_terms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      board.finish_check();

      if (board.failures == 0)
         $display("kt_minmod_flux_divergence regression: pass");
      else
         $display("kt_minmod_flux_divergence regression: fail");
      $finish;
   end

   // watchdog, far past the slowest legal run
   initial begin
      #(3_000_000);
      $display("kt_minmod_flux_divergence regression: fail");
      $finish;
   end

endmodule
